[rtl/lrmp_pkg.sv]
// ----------------------------------------------------------------------------
// lrmp_pkg
// Shared constants, types and address helpers for the matrix power block.
// ----------------------------------------------------------------------------
package lrmp_pkg;

  localparam int ORDER     = 10;
  localparam int LAST_SEED = 9;
  localparam int MEM_DEPTH = 3 * ORDER * ORDER;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int ACC_W     = 36;

  // Matrix regions in the shared store.
  localparam logic [AW-1:0] BASE_B = AW'(0);
  localparam logic [AW-1:0] BASE_A = AW'(ORDER * ORDER);
  localparam logic [AW-1:0] BASE_T = AW'(2 * ORDER * ORDER);

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [15:0]   data;
  } wr_t;

  function automatic logic [AW-1:0] mat_addr(logic [AW-1:0] base, logic [3:0] r,
                                             logic [3:0] c);
    logic [AW-1:0] rr;
    rr = AW'(r);
    return base + (rr << 3) + (rr << 1) + AW'(c);
  endfunction

endpackage

[rtl/lrmp_if.sv]
// ----------------------------------------------------------------------------
// lrmp_if
// Request and response channels of the matrix power block.
// ----------------------------------------------------------------------------
interface lrmp_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] index;
  logic [15:0] modulus;
  logic [15:0] coef_lag1;
  logic [15:0] coef_lag2;
  logic [15:0] coef_lag3;
  logic [15:0] coef_lag4;
  logic [15:0] coef_lag5;
  logic [15:0] coef_lag6;
  logic [15:0] coef_lag7;
  logic [15:0] coef_lag8;
  logic [15:0] coef_lag9;
  logic [15:0] coef_lag10;

  modport source (output valid, index, modulus, coef_lag1, coef_lag2, coef_lag3,
                  coef_lag4, coef_lag5, coef_lag6, coef_lag7, coef_lag8, coef_lag9,
                  coef_lag10, input ready);
  modport sink (input valid, index, modulus, coef_lag1, coef_lag2, coef_lag3,
                coef_lag4, coef_lag5, coef_lag6, coef_lag7, coef_lag8, coef_lag9,
                coef_lag10, output ready);
endinterface

interface lrmp_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] term_value;

  modport source (output valid, term_value, input ready);
  modport sink (input valid, term_value, output ready);
endinterface

[rtl/lrmp_modred.sv]
// ----------------------------------------------------------------------------
// lrmp_modred
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lrmp_modred
  import lrmp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] dividend,
  input  logic [15:0]      modulus,
  output logic             done,
  output logic [15:0]      remainder
);

  logic [ACC_W-1:0] dvd;
  logic [15:0]      rem;
  logic [15:0]      m;
  logic [5:0]       cnt;
  logic             busy;
  logic [16:0]      trial;

  assign trial     = {rem, dvd[ACC_W-1]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(ACC_W);
        dvd  <= dividend;
        rem  <= '0;
        m    <= modulus;
      end else if (busy) begin
        dvd <= dvd << 1;
        if (trial >= {1'b0, m}) begin
          rem <= 16'(trial - {1'b0, m});
        end else begin
          rem <= trial[15:0];
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/lrmp_matram.sv]
// ----------------------------------------------------------------------------
// lrmp_matram
// Matrix store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lrmp_matram
  import lrmp_pkg::*;
(
  input  logic          clk,
  input  wr_t           wr,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [15:0]   rdata_a,
  output logic [15:0]   rdata_b
);

  logic [15:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/linear_recurrence_matrix_power.sv]
// ----------------------------------------------------------------------------
// linear_recurrence_matrix_power
// Order-ten linear recurrence mod m by square-and-multiply of the companion
// matrix, using one multiplier and one shared remainder unit.
// ----------------------------------------------------------------------------
// Channel  Dir  Word
// req      in   index, modulus, coef_lag1..coef_lag10
// rsp      out  term_value
//
// A word with index of 9 or below goes straight to the remainder unit; a zero
// modulus gives zero. Otherwise each matrix product runs, per element, a
// ten-term multiply-accumulate and a remainder, then a copy.
// There are popcount(index-9) + bits(index-9) products after the init pass.
// Reset is synchronous; the store needs no clearing. req is taken only when
// the sequencer is idle; a finished result may wait in the output register.
module linear_recurrence_matrix_power
  import lrmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lrmp_req_if.sink   req,
  lrmp_rsp_if.source rsp
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_CHK   = 4'd2;
  localparam logic [3:0] ST_MAC   = 4'd3;
  localparam logic [3:0] ST_MACE  = 4'd4;
  localparam logic [3:0] ST_DIVS  = 4'd5;
  localparam logic [3:0] ST_DIVW  = 4'd6;
  localparam logic [3:0] ST_COPY  = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  localparam logic [1:0] MODE_MUL = 2'd0;
  localparam logic [1:0] MODE_SQ  = 2'd1;
  localparam logic [1:0] MODE_FIN = 2'd2;

  logic [3:0]       state;
  logic [1:0]       mode;
  logic [31:0]      p;
  logic [15:0]      m;
  logic [15:0]      coef [ORDER];
  logic [3:0]       i, j, k, kd;
  logic             init_a;
  logic [6:0]       e;
  logic             rd_v;
  logic [ACC_W-1:0] acc;
  logic [15:0]      result;
  logic             out_valid;
  logic [15:0]      out_data;

  logic             div_start, div_done;
  logic [15:0]      div_rem;
  wr_t              wr;
  logic [AW-1:0]    raddr_a, raddr_b;
  logic [15:0]      rdata_a, rdata_b;
  logic [15:0]      opb;
  logic [31:0]      prod;
  logic [AW-1:0]    xbase, ybase, dbase;
  logic             accepted;

  assign req.ready      = (state == ST_IDLE);
  assign accepted       = req.valid && req.ready;
  assign rsp.valid      = out_valid;
  assign rsp.term_value = out_data;
  assign div_start      = (state == ST_DIVS);

  assign xbase = (mode == MODE_FIN) ? BASE_A : BASE_B;
  assign ybase = (mode == MODE_MUL) ? BASE_A : BASE_B;
  assign dbase = (mode == MODE_MUL) ? BASE_A : BASE_B;

  always_comb begin
    raddr_a = mat_addr(xbase, i, k);
    raddr_b = mat_addr(ybase, k, j);
    if (state == ST_COPY) begin
      raddr_a = BASE_T + AW'(e);
    end
  end

  // In the final pass the second operand is the start vector, f(9-k) = 9-k.
  assign opb  = (mode == MODE_FIN) ? 16'(4'(LAST_SEED) - kd) : rdata_b;
  assign prod = rdata_a * opb;

  always_comb begin
    wr = '0;
    unique case (state)
      ST_INIT: begin
        wr.en   = 1'b1;
        wr.addr = mat_addr(init_a ? BASE_A : BASE_B, i, k);
        if (init_a) begin
          wr.data = (i == k) ? 16'd1 : 16'd0;
        end else if (i == 4'd0) begin
          wr.data = coef[k];
        end else begin
          wr.data = (i == k + 4'd1) ? 16'd1 : 16'd0;
        end
      end
      ST_DIVW: begin
        wr.en   = div_done && (mode != MODE_FIN);
        wr.addr = mat_addr(BASE_T, i, j);
        wr.data = div_rem;
      end
      ST_COPY: begin
        wr.en   = (e != 7'd0);
        wr.addr = dbase + AW'(e - 7'd1);
        wr.data = rdata_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accepted) begin
      coef[0] <= req.coef_lag1;
      coef[1] <= req.coef_lag2;
      coef[2] <= req.coef_lag3;
      coef[3] <= req.coef_lag4;
      coef[4] <= req.coef_lag5;
      coef[5] <= req.coef_lag6;
      coef[6] <= req.coef_lag7;
      coef[7] <= req.coef_lag8;
      coef[8] <= req.coef_lag9;
      coef[9] <= req.coef_lag10;
      m       <= req.modulus;
    end
    kd <= k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_FIN;
      out_valid <= 1'b0;
      rd_v      <= 1'b0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      e         <= '0;
      init_a    <= 1'b0;
    end else begin
      rd_v <= (state == ST_MAC);
      if (rd_v) begin
        acc <= acc + ACC_W'(prod);
      end
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accepted) begin
            acc  <= ACC_W'(req.index);
            p    <= req.index - 32'(LAST_SEED);
            mode <= MODE_FIN;
            i    <= '0;
            k    <= '0;
            if (req.modulus == 16'd0) begin
              result <= '0;
              state  <= ST_DONE;
            end else if (req.index <= 32'(LAST_SEED)) begin
              state <= ST_DIVS;
            end else begin
              init_a <= 1'b0;
              state  <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          if (k == 4'(ORDER - 1)) begin
            k <= '0;
            if (i == 4'(ORDER - 1)) begin
              i <= '0;
              if (init_a) begin
                state <= ST_CHK;
              end
              init_a <= 1'b1;
            end else begin
              i <= i + 4'd1;
            end
          end else begin
            k <= k + 4'd1;
          end
        end
        ST_CHK: begin
          i   <= '0;
          j   <= '0;
          k   <= '0;
          acc <= '0;
          if (p == 32'd0) begin
            mode <= MODE_FIN;
          end else if (p[0]) begin
            mode <= MODE_MUL;
          end else begin
            mode <= MODE_SQ;
          end
          state <= ST_MAC;
        end
        ST_MAC: begin
          if (k == 4'(ORDER - 1)) begin
            state <= ST_MACE;
          end else begin
            k <= k + 4'd1;
          end
        end
        ST_MACE: state <= ST_DIVS;
        ST_DIVS: state <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            acc <= '0;
            k   <= '0;
            if (mode == MODE_FIN) begin
              result <= div_rem;
              state  <= ST_DONE;
            end else if (j == 4'(ORDER - 1)) begin
              j <= '0;
              if (i == 4'(ORDER - 1)) begin
                i     <= '0;
                e     <= '0;
                state <= ST_COPY;
              end else begin
                i     <= i + 4'd1;
                state <= ST_MAC;
              end
            end else begin
              j     <= j + 4'd1;
              state <= ST_MAC;
            end
          end
        end
        ST_COPY: begin
          if (e == 7'(ORDER * ORDER)) begin
            e <= '0;
            if (mode == MODE_MUL) begin
              mode  <= MODE_SQ;
              state <= ST_MAC;
            end else begin
              p     <= p >> 1;
              state <= ST_CHK;
            end
          end else begin
            e <= e + 7'd1;
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_data  <= result;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  lrmp_modred u_modred (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (acc),
    .modulus   (m),
    .done      (div_done),
    .remainder (div_rem)
  );

  lrmp_matram u_matram (
    .clk     (clk),
    .wr      (wr),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

endmodule

[rtl/lrmp_checker.sv]
// ----------------------------------------------------------------------------
// lrmp_checker
// Port-level checks on the matrix power block, bound to its top level.
// ----------------------------------------------------------------------------
module lrmp_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] term_value
);

  // The block works on one word at a time, so it is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req ready right after an accepted word");

  a_no_rsp_out_of_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_rsp_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(term_value))
    else $error("response changed while stalled");

endmodule

bind linear_recurrence_matrix_power lrmp_checker u_lrmp_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .term_value (rsp.term_value)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the order-ten recurrence block against a matrix-power predictor.
// Directed words cover the small-index, zero and unit modulus cases and the
// field extremes. Random words follow under four idle and stall patterns on
// both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import lrmp_pkg::*;

  typedef longint unsigned u64_t;
  typedef u64_t mat_t [ORDER][ORDER];

  typedef struct {
    logic [31:0] index;
    logic [15:0] modulus;
    logic [15:0] coef [ORDER];
  } term_req_t;

  localparam int WATCHDOG_LIMIT = 2000000;

  logic clk;
  logic rst;

  lrmp_req_if req ();
  lrmp_rsp_if rsp ();

  linear_recurrence_matrix_power i_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  logic [15:0] term_expected [$];
  int          error_count;
  int          words_sent;
  int          terms_checked;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void mat_product(input mat_t a, input mat_t b, output mat_t r,
                                      input u64_t m);
    u64_t sum;
    for (int i = 0; i < ORDER; i++) begin
      for (int j = 0; j < ORDER; j++) begin
        sum = 0;
        for (int k = 0; k < ORDER; k++) begin
          sum = (sum + (a[i][k] * b[k][j]) % m) % m;
        end
        r[i][j] = sum;
      end
    end
  endfunction

  function automatic logic [15:0] predict_term(input term_req_t w);
    u64_t m;
    u64_t p;
    u64_t sum;
    mat_t step;
    mat_t power;
    mat_t tmp;
    m = u64_t'(w.modulus);
    if (m == 0) return 16'd0;
    if (w.index <= LAST_SEED) return 16'(u64_t'(w.index) % m);
    for (int i = 0; i < ORDER; i++) begin
      for (int j = 0; j < ORDER; j++) begin
        step[i][j]  = 0;
        power[i][j] = (i == j) ? (1 % m) : 0;
      end
    end
    for (int i = 0; i < ORDER; i++) step[0][i] = u64_t'(w.coef[i]) % m;
    for (int i = 0; i + 1 < ORDER; i++) step[i + 1][i] = 1 % m;
    p = u64_t'(w.index) - LAST_SEED;
    while (p != 0) begin
      if (p[0]) begin
        mat_product(step, power, tmp, m);
        power = tmp;
      end
      mat_product(step, step, tmp, m);
      step = tmp;
      p = p >> 1;
    end
    // The seed vector holds f(9) down to f(0).
    sum = 0;
    for (int i = 0; i < ORDER; i++) begin
      sum = (sum + (power[0][i] * (u64_t'(LAST_SEED - i) % m)) % m) % m;
    end
    return 16'(sum);
  endfunction

  // ------------------------------------------------------------------ drivers
  task automatic send_word(input term_req_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.index      <= w.index;
    req.modulus    <= w.modulus;
    req.coef_lag1  <= w.coef[0];
    req.coef_lag2  <= w.coef[1];
    req.coef_lag3  <= w.coef[2];
    req.coef_lag4  <= w.coef[3];
    req.coef_lag5  <= w.coef[4];
    req.coef_lag6  <= w.coef[5];
    req.coef_lag7  <= w.coef[6];
    req.coef_lag8  <= w.coef[7];
    req.coef_lag9  <= w.coef[8];
    req.coef_lag10 <= w.coef[9];
    do @(posedge clk); while (!req.ready);
    term_expected.push_back(predict_term(w));
    words_sent++;
  endtask

  task automatic drain;
    @(posedge clk);
    req.valid <= 1'b0;
    while (term_expected.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ------------------------------------------------------------------ checker
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (term_expected.size() == 0) begin
        report_mismatch("unexpected word", rsp.term_value, 16'd0);
      end else begin
        logic [15:0] want;
        want = term_expected.pop_front();
        if (rsp.term_value !== want) report_mismatch("term_value", rsp.term_value, want);
        terms_checked++;
      end
    end
  end

  // Counts cycles with no word moving on either channel.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results pending", term_expected.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------- tests
  function automatic term_req_t make_word(input logic [31:0] index,
                                          input logic [15:0] modulus,
                                          input logic [15:0] coef_fill);
    term_req_t w;
    w.index   = index;
    w.modulus = modulus;
    foreach (w.coef[i]) w.coef[i] = coef_fill;
    return w;
  endfunction

  function automatic term_req_t random_word;
    term_req_t w;
    int        pick;
    pick = $urandom_range(99);
    foreach (w.coef[i]) w.coef[i] = 16'($urandom);
    w.modulus = ($urandom_range(9) == 0) ? 16'd1 : 16'($urandom_range(2, 65535));
    if ($urandom_range(3) == 0) w.modulus = 16'($urandom_range(2, 40));
    if (pick < 30) begin
      w.index = $urandom_range(0, LAST_SEED);
    end else if (pick < 36) begin
      w.index   = $urandom;
      w.modulus = 16'd0;
    end else if (pick < 99) begin
      // Short exponents keep the run length reasonable.
      w.index = $urandom_range(LAST_SEED + 1, LAST_SEED + 16);
    end else begin
      w.index = $urandom;
    end
    return w;
  endfunction

  task automatic test_directed;
    term_req_t w;
    send_word(make_word(32'd0, 16'd0, 16'd0));
    send_word(make_word(32'hFFFF_FFFF, 16'd0, 16'hFFFF));
    send_word(make_word(32'd5, 16'd3, 16'd0));
    send_word(make_word(32'd9, 16'hFFFF, 16'hFFFF));
    send_word(make_word(32'd9, 16'd1, 16'd0));
    send_word(make_word(32'd3, 16'd1, 16'hFFFF));
    send_word(make_word(32'd10, 16'hFFFF, 16'hFFFF));
    send_word(make_word(32'd10, 16'd1, 16'd1));
    send_word(make_word(32'd11, 16'd7, 16'd1));
    send_word(make_word(32'd20, 16'd2, 16'd0));
    send_word(make_word(32'd1000, 16'd97, 16'd3));
    w = make_word(32'd12, 16'd65521, 16'd0);
    foreach (w.coef[i]) w.coef[i] = (i % 2 == 0) ? 16'hFFFF : 16'h0001;
    send_word(w);
    w = make_word(32'hFFFF_FFFF, 16'hFFFF, 16'd0);
    foreach (w.coef[i]) w.coef[i] = 16'($urandom);
    send_word(w);
    drain();
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_word(random_word());
    drain();
  endtask

  initial begin
    error_count    = 0;
    words_sent     = 0;
    terms_checked  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    idle_cycles    = 0;
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.index      <= '0;
    req.modulus    <= '0;
    req.coef_lag1  <= '0;
    req.coef_lag2  <= '0;
    req.coef_lag3  <= '0;
    req.coef_lag4  <= '0;
    req.coef_lag5  <= '0;
    req.coef_lag6  <= '0;
    req.coef_lag7  <= '0;
    req.coef_lag8  <= '0;
    req.coef_lag9  <= '0;
    req.coef_lag10 <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(38, 0, 0);
    test_random(38, 73, 0);
    test_random(38, 0, 73);
    test_random(38, 37, 37);

    $display("Sent %0d words and checked %0d terms across four idle and stall patterns,",
             words_sent, terms_checked);
    $display("including small indexes, zero and unit moduli and full 32-bit indexes.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lrmp_pkg.sv
rtl/lrmp_if.sv
rtl/lrmp_modred.sv
rtl/lrmp_matram.sv
rtl/linear_recurrence_matrix_power.sv
rtl/lrmp_checker.sv
tb/sv/tb_top.sv
